/* design/wld_pkg.sv */
// ----------------------------------------------------------------------------
// wld_pkg
// Shared widths, codes and types of the waypoint line deviation monitor.
// ----------------------------------------------------------------------------
package wld_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS       = 16;
	localparam int DATA_W          = 32;
	localparam int ID_W            = 32;
	localparam int LIMIT_W         = 32;
	localparam int ACTION_W        = 2;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;

	localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT_RST = LIMIT_W'(64'd1 << FRAC_BITS);

	typedef enum logic [ACTION_W-1:0] {
		ACT_WAYPOINT = 2'd0,
		ACT_POSE     = 2'd1,
		ACT_EVAL     = 2'd2
	} action_t;

	localparam logic REG_DEFAULT_LIMIT = 1'b0;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

/* design/wld_if.sv */
// ----------------------------------------------------------------------------
// wld_if
// Command and result channels of the waypoint line deviation monitor.
// ----------------------------------------------------------------------------
interface wld_cmd_if import wld_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic signed [DATA_W-1:0]  pos_x;
	logic signed [DATA_W-1:0]  pos_y;
	logic [ID_W-1:0]           point_id;
	logic [LIMIT_W-1:0]        limit;

	modport source (output valid, action, pos_x, pos_y, point_id, limit, input ready);
	modport sink (input valid, action, pos_x, pos_y, point_id, limit, output ready);
endinterface

interface wld_rsp_if import wld_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [DATA_W-1:0]         distance;
	logic                      emergency;
	logic signed [DATA_W-1:0]  cur_wp_x;
	logic signed [DATA_W-1:0]  cur_wp_y;
	logic [ID_W-1:0]           cur_wp_id;
	logic signed [DATA_W-1:0]  prev_wp_x;
	logic signed [DATA_W-1:0]  prev_wp_y;
	logic [ID_W-1:0]           prev_wp_id;

	modport source (output valid, distance, emergency, cur_wp_x, cur_wp_y, cur_wp_id,
		prev_wp_x, prev_wp_y, prev_wp_id, input ready);
	modport sink (input valid, distance, emergency, cur_wp_x, cur_wp_y, cur_wp_id,
		prev_wp_x, prev_wp_y, prev_wp_id, output ready);
endinterface

/* design/waypoint_line_deviation_monitor.sv */
// ----------------------------------------------------------------------------
// waypoint_line_deviation_monitor
// Keeps two waypoints and the vehicle pose; reports cross-track distance.
// ----------------------------------------------------------------------------
// cmd channel: one transfer per item. action 0 loads a waypoint (the old
// current waypoint moves to previous when the id changes), action 1 loads the
// vehicle pose, action 2 asks for an evaluation, action 3 is dropped.
// rsp channel: one transfer per evaluation with the distance, the emergency
// flag and both stored waypoints.
// Updates are registered at the transfer. An evaluation of an origin or
// axis-parallel line passes through S_OUT to the result register; a general
// line runs four bit-serial multiplies, a square root and a division, with
// hand-offs between the units, before S_OUT. One item is in work at a time.
// The result register frees cmd again as soon as a result is loaded; a stalled
// rsp holds its transfer, and only a following evaluation waits for it.
// Reset clears both waypoints, the pose and the ids, and loads the limit from
// default_limit (1.0); a write of default_limit updates the active limit
// until the first waypoint arrives.
// ----------------------------------------------------------------------------
module waypoint_line_deviation_monitor import wld_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	wld_cmd_if.sink                cmd,
	wld_rsp_if.source              rsp,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);
	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int AW = PW + 1;
	localparam int SW = DW + 1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MUL1 = 8'b0000_0010,
		S_MUL2 = 8'b0000_0100,
		S_MUL3 = 8'b0000_1000,
		S_MUL4 = 8'b0001_0000,
		S_SQRT = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	function automatic logic signed [DW-1:0] sdiff(logic signed [CW-1:0] a,
		logic signed [CW-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	function automatic logic [DATA_W-1:0] sat32(logic [DW-1:0] v);
		return (v > DW'({DATA_W{1'b1}})) ? '1 : DATA_W'(v);
	endfunction

	function automatic logic signed [AW-1:0] sprod(logic [PW-1:0] p, logic neg);
		logic signed [AW-1:0] v;
		v = AW'(p);
		return neg ? -v : v;
	endfunction

	state_t state_q;

	logic [LIMIT_W-1:0]       dflt_limit_q;
	logic [LIMIT_W-1:0]       act_limit_q;
	logic                     wp_seen_q;
	logic signed [CW-1:0]     cur_x_q, cur_y_q, prv_x_q, prv_y_q, veh_x_q, veh_y_q;
	logic [ID_W-1:0]          cur_id_q, prv_id_q;

	logic [DW-1:0]            mdx_q, mdy_q, mex_q, mey_q;
	logic                     sgn1_q, sgn2_q;
	logic signed [AW-1:0]     t1_q;
	logic [AW-1:0]            c_q;
	logic [AW-1:0]            l2_q;
	logic [DATA_W-1:0]        d_q;
	logic                     mul_start_q, sqrt_start_q, div_start_q;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_dist_q;
	logic                     out_emer_q;
	logic signed [DATA_W-1:0] out_cx_q, out_cy_q, out_px_q, out_py_q;
	logic [ID_W-1:0]          out_cid_q, out_pid_q;

	logic signed [DW-1:0]     dx, dy, ex, ey, vx, vy;
	logic                     at_origin, vert, horz;
	logic                     cmd_xfer, cfg_wr;
	logic [DW-1:0]            mul_a, mul_b;
	logic [PW-1:0]            prod;
	logic signed [AW-1:0]     cdiff;
	logic [SW-1:0]            root;
	logic [DATA_W-1:0]        quot;
	unit_stat_t               mul_stat, sqrt_stat, div_stat;

	assign dx = sdiff(prv_x_q, cur_x_q);
	assign dy = sdiff(prv_y_q, cur_y_q);
	assign ex = sdiff(veh_x_q, cur_x_q);
	assign ey = sdiff(veh_y_q, cur_y_q);
	assign vx = sdiff(veh_x_q, prv_x_q);
	assign vy = sdiff(veh_y_q, prv_y_q);

	assign at_origin = (cur_x_q == '0 && cur_y_q == '0) || (prv_x_q == '0 && prv_y_q == '0);
	assign vert      = cur_x_q == prv_x_q;
	assign horz      = cur_y_q == prv_y_q;

	assign cmd.ready = state_q == S_IDLE;
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_DEFAULT_LIMIT) ? dflt_limit_q : '0;

	always_comb begin
		case (state_q)
			S_MUL1: begin
				mul_a = mdy_q;
				mul_b = mex_q;
			end
			S_MUL2: begin
				mul_a = mey_q;
				mul_b = mdx_q;
			end
			S_MUL4: begin
				mul_a = mdy_q;
				mul_b = mdy_q;
			end
			default: begin
				mul_a = mdx_q;
				mul_b = mdx_q;
			end
		endcase
	end

	assign cdiff = t1_q - sprod(prod, sgn2_q);

	wld_mul #(.OP_W(DW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.stat   (mul_stat)
	);

	wld_sqrt #(.ROOT_W(SW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start_q),
		.rad    ((2*SW)'(l2_q)),
		.root   (root),
		.stat   (sqrt_stat)
	);

	wld_div #(.DVD_W(AW), .DVS_W(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (c_q),
		.divisor  (root),
		.quot     (quot),
		.stat     (div_stat)
	);

	// stored waypoints, pose and limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_limit_q <= DEFAULT_LIMIT_RST;
			act_limit_q  <= DEFAULT_LIMIT_RST;
			wp_seen_q    <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			cur_id_q     <= '0;
			prv_x_q      <= '0;
			prv_y_q      <= '0;
			prv_id_q     <= '0;
			veh_x_q      <= '0;
			veh_y_q      <= '0;
		end else begin
			if (cfg_wr && paddr[2] == REG_DEFAULT_LIMIT) begin
				dflt_limit_q <= pwdata;
				if (!wp_seen_q) begin
					act_limit_q <= pwdata;
				end
			end
			if (cmd_xfer && cmd.action == ACT_WAYPOINT) begin
				if (cmd.point_id != cur_id_q) begin
					prv_x_q  <= cur_x_q;
					prv_y_q  <= cur_y_q;
					prv_id_q <= cur_id_q;
				end
				cur_x_q     <= CW'(cmd.pos_x);
				cur_y_q     <= CW'(cmd.pos_y);
				cur_id_q    <= cmd.point_id;
				act_limit_q <= cmd.limit;
				wp_seen_q   <= 1'b1;
			end
			if (cmd_xfer && cmd.action == ACT_POSE) begin
				veh_x_q <= CW'(cmd.pos_x);
				veh_y_q <= CW'(cmd.pos_y);
			end
		end
	end

	// evaluation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mul_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			mul_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_xfer && cmd.action == ACT_EVAL) begin
						if (at_origin || vert || horz) begin
							state_q <= S_OUT;
						end else begin
							state_q     <= S_MUL1;
							mul_start_q <= 1'b1;
						end
					end
				end
				S_MUL1: begin
					if (mul_stat.done) begin
						state_q     <= S_MUL2;
						mul_start_q <= 1'b1;
					end
				end
				S_MUL2: begin
					if (mul_stat.done) begin
						state_q     <= S_MUL3;
						mul_start_q <= 1'b1;
					end
				end
				S_MUL3: begin
					if (mul_stat.done) begin
						state_q     <= S_MUL4;
						mul_start_q <= 1'b1;
					end
				end
				S_MUL4: begin
					if (mul_stat.done) begin
						state_q      <= S_SQRT;
						sqrt_start_q <= 1'b1;
					end
				end
				S_SQRT: begin
					if (sqrt_stat.done) begin
						state_q     <= S_DIV;
						div_start_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_xfer && cmd.action == ACT_EVAL) begin
			mdx_q  <= mag(dx);
			mdy_q  <= mag(dy);
			mex_q  <= mag(ex);
			mey_q  <= mag(ey);
			sgn1_q <= dy[DW-1] ^ ex[DW-1];
			sgn2_q <= ey[DW-1] ^ dx[DW-1];
			if (at_origin) begin
				d_q <= '0;
			end else if (vert) begin
				d_q <= sat32(mag(vx));
			end else begin
				d_q <= sat32(mag(vy));
			end
		end
		if (mul_stat.done) begin
			case (state_q)
				S_MUL1:  t1_q <= sprod(prod, sgn1_q);
				S_MUL2:  c_q  <= cdiff[AW-1] ? AW'(-cdiff) : AW'(cdiff);
				S_MUL3:  l2_q <= AW'(prod);
				S_MUL4:  l2_q <= l2_q + AW'(prod);
				default: t1_q <= t1_q;
			endcase
		end
		if (state_q == S_DIV && div_stat.done) begin
			d_q <= quot;
		end
		if (state_q == S_OUT && (!out_valid_q || rsp.ready)) begin
			out_dist_q <= d_q;
			out_emer_q <= d_q > act_limit_q;
			out_cx_q   <= DATA_W'(cur_x_q);
			out_cy_q   <= DATA_W'(cur_y_q);
			out_cid_q  <= cur_id_q;
			out_px_q   <= DATA_W'(prv_x_q);
			out_py_q   <= DATA_W'(prv_y_q);
			out_pid_q  <= prv_id_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.distance  = out_dist_q;
	assign rsp.emergency = out_emer_q;
	assign rsp.cur_wp_x  = out_cx_q;
	assign rsp.cur_wp_y  = out_cy_q;
	assign rsp.cur_wp_id = out_cid_q;
	assign rsp.prev_wp_x = out_px_q;
	assign rsp.prev_wp_y = out_py_q;
	assign rsp.prev_wp_id = out_pid_q;

`ifndef SYNTHESIS
	a_mul_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == S_MUL1 || state_q == S_MUL2 ||
			state_q == S_MUL3 || state_q == S_MUL4))
		else $error("multiplier finished outside a multiply phase");
	a_div_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output phase");
	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |-> !(mul_stat.busy || sqrt_stat.busy || div_stat.busy))
		else $error("command taken while an arithmetic unit is busy");
`endif
endmodule

/* design/wld_mul.sv */
// ----------------------------------------------------------------------------
// wld_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wld_mul import wld_pkg::*; #(
	parameter int OP_W = COORD_WIDTH_DEF + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_W-1:0]     a,
	input  logic [OP_W-1:0]     b,
	output logic [2*OP_W-1:0]   prod,
	output unit_stat_t          stat
);
	localparam int CNT_W = $clog2(OP_W + 1);

	logic [OP_W-1:0]   a_q;
	logic [2*OP_W-1:0] p_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [OP_W:0]     sum;

	assign sum = {1'b0, p_q[2*OP_W-1:OP_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{OP_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[OP_W-1:1]};
		end
	end

	assign prod = p_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

/* design/wld_sqrt.sv */
// ----------------------------------------------------------------------------
// wld_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wld_sqrt import wld_pkg::*; #(
	parameter int ROOT_W = COORD_WIDTH_DEF + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   rad,
	output logic [ROOT_W-1:0]     root,
	output unit_stat_t            stat
);
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  x_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

/* design/wld_div.sv */
// ----------------------------------------------------------------------------
// wld_div
// Restoring divider, one dividend bit per cycle, with a saturating quotient.
// ----------------------------------------------------------------------------
module wld_div import wld_pkg::*; #(
	parameter int DVD_W = 2 * COORD_WIDTH_DEF + 5,
	parameter int DVS_W = COORD_WIDTH_DEF + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [DVS_W-1:0]   divisor,
	output logic [DATA_W-1:0]  quot,
	output unit_stat_t         stat
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DATA_W-1:0] q_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    r2;
	logic [DVS_W:0]    diff;
	logic              ge;

	assign r2   = {rem_q, dvd_q[DVD_W-1]};
	assign diff = r2 - {1'b0, dvs_q};
	assign ge   = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DVS_W-1:0] : r2[DVS_W-1:0];
			q_q   <= {q_q[DATA_W-2:0], ge};
			ovf_q <= ovf_q | q_q[DATA_W-1];
		end
	end

	assign quot = ovf_q ? '1 : q_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule
